/* sv/oerd_pkg.sv */
// ----------------------------------------------------------------------------
// Odd-even route directions package
// Shared payload types, direction codes and coordinate clamps for the
// odd-even turn-model route computation.
// ----------------------------------------------------------------------------
package oerd_pkg;

   // Mesh size limits. Coordinates at or above a limit saturate to its last index.
   localparam int unsigned MAX_COLUMNS = 16;
   localparam int unsigned MAX_ROWS    = 16;
   localparam int unsigned MAX_LAYERS  = 4;

   // Bit positions of the direction flags.
   localparam int unsigned DIR_NORTH = 0;
   localparam int unsigned DIR_EAST  = 1;
   localparam int unsigned DIR_SOUTH = 2;
   localparam int unsigned DIR_WEST  = 3;
   localparam int unsigned DIR_UP    = 4;
   localparam int unsigned DIR_DOWN  = 5;
   localparam int unsigned NUM_DIRS  = 6;

   // Previous hop codes.
   localparam logic [2:0] PREV_NORTH = 3'd0;
   localparam logic [2:0] PREV_EAST  = 3'd1;

   // Input item.
   typedef struct packed {
      logic [3:0] src_x;
      logic [3:0] src_y;
      logic [1:0] src_z;
      logic [3:0] cur_x;
      logic [3:0] cur_y;
      logic [1:0] cur_z;
      logic [3:0] dst_x;
      logic [3:0] dst_y;
      logic [1:0] dst_z;
      logic [2:0] last_hop;
   } req_type;

   // Result item.
   typedef struct packed {
      logic       allow_north;
      logic       allow_east;
      logic       allow_south;
      logic       allow_west;
      logic       allow_up;
      logic       allow_down;
      logic [1:0] legal_count;
   } rsp_type;

   // Decoded offsets and parities that the flag logic works from.
   typedef struct packed {
      logic dx_zero;
      logic dx_pos;
      logic dx_gt1;
      logic dy_zero;
      logic dy_pos;
      logic dy_gt1;
      logic dz_zero;
      logic dz_pos;
      logic cx_odd;
      logic cy_odd;
      logic tx_odd;
      logic ty_odd;
      logic cx_eq_sx;
      logic cy_eq_sy;
      logic prev_east;
      logic prev_north;
   } cond_type;

   // Saturate a column to the last column of the mesh.
   function automatic logic [3:0] clamp_col(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (32'(v) >= MAX_COLUMNS) begin
         r = 4'(MAX_COLUMNS - 1);
      end
      return r;
   endfunction

   // Saturate a row to the last row of the mesh.
   function automatic logic [3:0] clamp_row(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (32'(v) >= MAX_ROWS) begin
         r = 4'(MAX_ROWS - 1);
      end
      return r;
   endfunction

   // Saturate a layer to the last layer of the mesh.
   function automatic logic [1:0] clamp_layer(input logic [1:0] v);
      logic [1:0] r;
      r = v;
      if (32'(v) >= MAX_LAYERS) begin
         r = 2'(MAX_LAYERS - 1);
      end
      return r;
   endfunction

endpackage

/* sv/oerd_flags.sv */
// ----------------------------------------------------------------------------
// Odd-even direction flags
// Turns decoded offsets and parities into the set of legal output directions
// under the odd-even turn rules, in 2D or 3D mode.
// ----------------------------------------------------------------------------
module oerd_flags
   import oerd_pkg::*;
(
   input  cond_type              cond,
   input  logic                  mode_3d,
   output logic [NUM_DIRS-1:0]   flags
);

   // Routing in the y-z plane, with the row parity playing the column's role.
   function automatic logic [NUM_DIRS-1:0] route_yz(input cond_type c,
                                                    input logic at_dst_x);
      logic [NUM_DIRS-1:0] f;
      f = '0;
      if (c.dy_zero) begin
         if (!c.dz_zero) begin
            if (c.dz_pos) begin
               f[DIR_UP] = 1'b1;
            end else begin
               f[DIR_DOWN] = 1'b1;
            end
         end else if (at_dst_x) begin
            f[DIR_DOWN] = 1'b1;
         end
      end else if (c.dy_pos) begin
         if (c.dz_zero) begin
            f[DIR_NORTH] = 1'b1;
         end else begin
            if (c.cy_odd || c.cy_eq_sy || !c.prev_north) begin
               if (c.dz_pos) begin
                  f[DIR_UP] = 1'b1;
               end else begin
                  f[DIR_DOWN] = 1'b1;
               end
            end
            if (c.ty_odd || c.dy_gt1) begin
               f[DIR_NORTH] = 1'b1;
            end
         end
      end else begin
         f[DIR_SOUTH] = 1'b1;
         if (!c.cy_odd && !c.dz_zero) begin
            if (c.dz_pos) begin
               f[DIR_UP] = 1'b1;
            end else begin
               f[DIR_DOWN] = 1'b1;
            end
         end
      end
      return f;
   endfunction

   logic turn_ok;
   logic dx_neg;

   // A turn off the eastbound axis is allowed in odd columns, at the source
   // column, or when the packet did not arrive heading east.
   assign turn_ok = cond.cx_odd || cond.cx_eq_sx || !cond.prev_east;
   assign dx_neg  = !cond.dx_zero && !cond.dx_pos;

   // Flag selection for both modes.
   always_comb begin
      flags = '0;
      if (!mode_3d) begin
         if (cond.dx_zero) begin
            if (cond.dy_pos) begin
               flags[DIR_NORTH] = 1'b1;
            end else begin
               flags[DIR_SOUTH] = 1'b1;
            end
         end else if (cond.dx_pos) begin
            if (cond.dy_zero) begin
               flags[DIR_EAST] = 1'b1;
            end else begin
               if (turn_ok) begin
                  if (cond.dy_pos) begin
                     flags[DIR_NORTH] = 1'b1;
                  end else begin
                     flags[DIR_SOUTH] = 1'b1;
                  end
               end
               if (cond.tx_odd || cond.dx_gt1) begin
                  flags[DIR_EAST] = 1'b1;
               end
            end
         end else begin
            flags[DIR_WEST] = 1'b1;
            if (!cond.cx_odd && !cond.dy_zero) begin
               if (cond.dy_pos) begin
                  flags[DIR_NORTH] = 1'b1;
               end else begin
                  flags[DIR_SOUTH] = 1'b1;
               end
            end
         end
      end else begin
         if (cond.dx_pos) begin
            if (cond.dy_zero && cond.dz_zero) begin
               flags[DIR_EAST] = 1'b1;
            end else begin
               if (cond.tx_odd || cond.dx_gt1) begin
                  flags[DIR_EAST] = 1'b1;
               end
               if (turn_ok) begin
                  flags = flags | route_yz(cond, 1'b0);
               end
            end
         end else if (dx_neg) begin
            flags[DIR_WEST] = 1'b1;
            if (!cond.cx_odd) begin
               flags = flags | route_yz(cond, 1'b0);
            end
         end else begin
            flags = route_yz(cond, 1'b1);
         end
      end
   end

endmodule

/* sv/odd_even_route_directions.sv */
// ----------------------------------------------------------------------------
// Odd-even route directions
// Route computation for a mesh network-on-chip router under the odd-even
// turn model, in 2D or 3D mode.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the output stalls. The three
// register stages are coordinate decode (clamping, offsets, parities), flag
// selection, and the output register with the flag count. When the output is
// stalled the whole pipeline holds and req_stall is raised; nothing is dropped
// or repeated. The mode register is written through the csr_ port, which is
// always ready, and must only change while no item is in flight.
module odd_even_route_directions
   import oerd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic                  mode_3d_ff;
   logic                  advance;

   logic                  s1_valid_ff;
   cond_type              s1_cond_ff;
   cond_type              s1_cond_in;

   logic                  s2_valid_ff;
   logic [NUM_DIRS-1:0]   s2_flags_ff;
   logic [NUM_DIRS-1:0]   s2_flags_in;

   logic                  rsp_valid_ff;
   rsp_type               rsp_payload_ff;
   rsp_type               rsp_payload_in;

   logic [3:0]            sx, sy, cx, cy, tx, ty;
   logic [1:0]            cz, tz;
   logic signed [4:0]     dx, dy;
   logic signed [2:0]     dz;
   logic [2:0]            flag_sum;

   // Mode register, written whenever the csr port presents an item.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_3d_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_3d_ff <= csr_data;
      end
   end

   // The pipeline moves as one unless a finished result is held by the output.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Stage one: clamp the coordinates and decode offsets and parities.
   always_comb begin
      sx = clamp_col(req_payload.src_x);
      sy = clamp_row(req_payload.src_y);
      cx = clamp_col(req_payload.cur_x);
      cy = clamp_row(req_payload.cur_y);
      cz = clamp_layer(req_payload.cur_z);
      tx = clamp_col(req_payload.dst_x);
      ty = clamp_row(req_payload.dst_y);
      tz = clamp_layer(req_payload.dst_z);
      dx = $signed({1'b0, tx}) - $signed({1'b0, cx});
      dy = $signed({1'b0, ty}) - $signed({1'b0, cy});
      dz = $signed({1'b0, tz}) - $signed({1'b0, cz});

      s1_cond_in.dx_zero    = (dx == 5'sd0);
      s1_cond_in.dx_pos     = !dx[4] && (dx != 5'sd0);
      s1_cond_in.dx_gt1     = !dx[4] && (dx != 5'sd0) && (dx != 5'sd1);
      s1_cond_in.dy_zero    = (dy == 5'sd0);
      s1_cond_in.dy_pos     = !dy[4] && (dy != 5'sd0);
      s1_cond_in.dy_gt1     = !dy[4] && (dy != 5'sd0) && (dy != 5'sd1);
      s1_cond_in.dz_zero    = (dz == 3'sd0);
      s1_cond_in.dz_pos     = !dz[2] && (dz != 3'sd0);
      s1_cond_in.cx_odd     = cx[0];
      s1_cond_in.cy_odd     = cy[0];
      s1_cond_in.tx_odd     = tx[0];
      s1_cond_in.ty_odd     = ty[0];
      s1_cond_in.cx_eq_sx   = (cx == sx);
      s1_cond_in.cy_eq_sy   = (cy == sy);
      s1_cond_in.prev_east  = (req_payload.last_hop == PREV_EAST);
      s1_cond_in.prev_north = (req_payload.last_hop == PREV_NORTH);
   end

   // Stage two: select the legal directions.
   oerd_flags u_flags (
      .cond    (s1_cond_ff),
      .mode_3d (mode_3d_ff),
      .flags   (s2_flags_in)
   );

   // Stage three: count the flags and form the result item.
   always_comb begin
      flag_sum = 3'($countones(s2_flags_ff));
      rsp_payload_in.allow_north = s2_flags_ff[DIR_NORTH];
      rsp_payload_in.allow_east  = s2_flags_ff[DIR_EAST];
      rsp_payload_in.allow_south = s2_flags_ff[DIR_SOUTH];
      rsp_payload_in.allow_west  = s2_flags_ff[DIR_WEST];
      rsp_payload_in.allow_up    = s2_flags_ff[DIR_UP];
      rsp_payload_in.allow_down  = s2_flags_ff[DIR_DOWN];
      rsp_payload_in.legal_count = flag_sum[1:0];
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Stage data, held together with the valid bits on a stall.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cond_ff     <= s1_cond_in;
         s2_flags_ff    <= s2_flags_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* sv/oerd_check.sv */
// ----------------------------------------------------------------------------
// Odd-even route directions checker
// Port-level assertions for the route computation, bound to the top level.
// ----------------------------------------------------------------------------
module oerd_check
   import oerd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   logic [NUM_DIRS-1:0] rsp_flags;

   assign rsp_flags = {rsp_payload.allow_north, rsp_payload.allow_east,
                       rsp_payload.allow_south, rsp_payload.allow_west,
                       rsp_payload.allow_up, rsp_payload.allow_down};

   // No result item is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid right after reset");

   // A stalled input item stays and keeps its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled input item changed");

   // A stalled result item stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   // The count agrees with the flags that are set.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.legal_count == 2'($countones(rsp_flags)))
      else $error("legal_count disagrees with the direction flags");

   // Opposite directions are never both legal.
   a_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.allow_east && rsp_payload.allow_west) &&
                    !(rsp_payload.allow_north && rsp_payload.allow_south) &&
                    !(rsp_payload.allow_up && rsp_payload.allow_down))
      else $error("opposite directions flagged together");

endmodule

bind odd_even_route_directions oerd_check u_oerd_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Odd-even route directions testbench
// Drives source, current and destination coordinates with a previous hop into
// the route computation, in 2D and 3D mode, and checks every set of direction
// flags against a typed table answer or a local odd-even turn-model predictor.
// A short directed table comes first, then 2000 random items in phases that
// alternate the mode, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import oerd_pkg::*;

   // Previous hop codes that the package does not name.
   localparam logic [2:0] PREV_SOUTH  = 3'd2;
   localparam logic [2:0] PREV_WEST   = 3'd3;
   localparam logic [2:0] PREV_UP     = 3'd4;
   localparam logic [2:0] PREV_DOWN   = 3'd5;
   localparam logic [2:0] PREV_NONE   = 3'd6;
   localparam logic [2:0] PREV_UNUSED = 3'd7;

   localparam int RANDOM_ITEMS = 2000;
   localparam int PHASE_ITEMS  = 500;
   localparam int DRAIN_CYCLES = 8;

   // One row of the directed table.
   typedef struct {
      bit      mode_3d;
      req_type item;
      bit      typed;
      rsp_type answer;
   } route_case_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   bit      mode_now;
   bit      calm;
   int      mismatch_count;
   rsp_type flags_expected_q[$];
   rsp_type oldest_flags;

   odd_even_route_directions dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #4 clock = ~clock;
   end

   // Saturate a coordinate to the last index of the mesh.
   function automatic int sat_coord(int v, int limit);
      return (v >= limit) ? limit - 1 : v;
   endfunction

   // Legal moves in the y-z plane under the row parity rule.
   function automatic logic [5:0] yz_moves(int dy, int dz, int cy, int sy, int ty,
                                           logic [2:0] prev, bit at_dst_x);
      logic [5:0] f;
      logic [2:0] vert;
      f    = '0;
      vert = (dz > 0) ? 3'(DIR_UP) : 3'(DIR_DOWN);
      if (dy == 0) begin
         if (dz != 0 || at_dst_x) begin
            f[vert] = 1'b1;
         end
      end else if (dy > 0) begin
         if (dz == 0) begin
            f[DIR_NORTH] = 1'b1;
         end else begin
            if ((cy & 1) != 0 || cy == sy || prev != PREV_NORTH) begin
               f[vert] = 1'b1;
            end
            if ((ty & 1) != 0 || dy > 1) begin
               f[DIR_NORTH] = 1'b1;
            end
         end
      end else begin
         f[DIR_SOUTH] = 1'b1;
         if ((cy & 1) == 0 && dz != 0) begin
            f[vert] = 1'b1;
         end
      end
      return f;
   endfunction

   // Expected direction flags for one item under the given mode.
   function automatic rsp_type predict_route(req_type item, bit mode_3d);
      int         sx, sy, cx, cy, cz, tx, ty, tz, dx, dy, dz;
      logic [2:0] ns;
      logic [5:0] f;
      rsp_type    r;
      sx = sat_coord(int'(item.src_x), MAX_COLUMNS);
      sy = sat_coord(int'(item.src_y), MAX_ROWS);
      cx = sat_coord(int'(item.cur_x), MAX_COLUMNS);
      cy = sat_coord(int'(item.cur_y), MAX_ROWS);
      cz = sat_coord(int'(item.cur_z), MAX_LAYERS);
      tx = sat_coord(int'(item.dst_x), MAX_COLUMNS);
      ty = sat_coord(int'(item.dst_y), MAX_ROWS);
      tz = sat_coord(int'(item.dst_z), MAX_LAYERS);
      dx = tx - cx;
      dy = ty - cy;
      dz = tz - cz;
      ns = (dy > 0) ? 3'(DIR_NORTH) : 3'(DIR_SOUTH);
      f  = '0;
      if (!mode_3d) begin
         if (dx == 0) begin
            f[ns] = 1'b1;
         end else if (dx > 0) begin
            if (dy == 0) begin
               f[DIR_EAST] = 1'b1;
            end else begin
               if ((cx & 1) != 0 || cx == sx || item.last_hop != PREV_EAST) begin
                  f[ns] = 1'b1;
               end
               if ((tx & 1) != 0 || dx != 1) begin
                  f[DIR_EAST] = 1'b1;
               end
            end
         end else begin
            f[DIR_WEST] = 1'b1;
            if ((cx & 1) == 0 && dy != 0) begin
               f[ns] = 1'b1;
            end
         end
      end else begin
         if (dx > 0) begin
            if (dy == 0 && dz == 0) begin
               f[DIR_EAST] = 1'b1;
            end else begin
               if ((tx & 1) != 0 || dx > 1) begin
                  f[DIR_EAST] = 1'b1;
               end
               if ((cx & 1) != 0 || cx == sx || item.last_hop != PREV_EAST) begin
                  f |= yz_moves(dy, dz, cy, sy, ty, item.last_hop, 1'b0);
               end
            end
         end else if (dx < 0) begin
            f[DIR_WEST] = 1'b1;
            if ((cx & 1) == 0) begin
               f |= yz_moves(dy, dz, cy, sy, ty, item.last_hop, 1'b0);
            end
         end else begin
            f = yz_moves(dy, dz, cy, sy, ty, item.last_hop, 1'b1);
         end
      end
      r.allow_north = f[DIR_NORTH];
      r.allow_east  = f[DIR_EAST];
      r.allow_south = f[DIR_SOUTH];
      r.allow_west  = f[DIR_WEST];
      r.allow_up    = f[DIR_UP];
      r.allow_down  = f[DIR_DOWN];
      r.legal_count = 2'($countones(f));
      return r;
   endfunction

   // Build an input item from its coordinates.
   function automatic req_type make_req(logic [3:0] sx, logic [3:0] sy, logic [1:0] sz,
                                        logic [3:0] cx, logic [3:0] cy, logic [1:0] cz,
                                        logic [3:0] tx, logic [3:0] ty, logic [1:0] tz,
                                        logic [2:0] prev);
      req_type r;
      r = '{sx, sy, sz, cx, cy, cz, tx, ty, tz, prev};
      return r;
   endfunction

   // Directed row; the answer only counts when typed is set.
   function automatic route_case_type make_case(bit mode_3d, req_type item, bit typed,
                                                rsp_type answer);
      route_case_type c;
      c.mode_3d = mode_3d;
      c.item    = item;
      c.typed   = typed;
      c.answer  = answer;
      return c;
   endfunction

   // Random item, mostly with short offsets and shared coordinates so that
   // the parity and turn rules are reached often.
   function automatic req_type random_route_req();
      logic [63:0] raw;
      req_type     r;
      int          pick;
      raw  = {$urandom, $urandom};
      r    = raw[32:0];
      pick = $urandom_range(0, 9);
      if (pick >= 3) begin
         r.dst_x = r.cur_x + 4'($urandom_range(0, 4)) - 4'd2;
         r.dst_y = r.cur_y + 4'($urandom_range(0, 4)) - 4'd2;
         r.dst_z = r.cur_z + 2'($urandom_range(0, 2)) - 2'd1;
      end
      if (pick >= 6) begin
         if ($urandom_range(0, 1) == 0) r.dst_x = r.cur_x;
         if ($urandom_range(0, 1) == 0) r.dst_y = r.cur_y;
         if ($urandom_range(0, 1) == 0) r.dst_z = r.cur_z;
      end
      if (pick >= 8) begin
         if ($urandom_range(0, 1) == 0) r.src_x = r.cur_x;
         if ($urandom_range(0, 1) == 0) r.src_y = r.cur_y;
         r.last_hop = ($urandom_range(0, 1) == 0) ? PREV_EAST : PREV_NORTH;
      end
      return r;
   endfunction

   // Random idle decision for either side.
   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 25);
   endfunction

   // Count a mismatch and report the first ones.
   task automatic report_mismatch(string what, int exp_val, int act_val);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
      end
   endtask

   // Offer one item, with random idle cycles first, and record its flags once
   // it is taken.
   task automatic send_item(req_type item, rsp_type expected_flags);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
      flags_expected_q = {flags_expected_q, expected_flags};
   endtask

   // Write the mode once everything in flight has come out.
   task automatic write_mode(bit mode_3d);
      req_valid <= 1'b0;
      while (flags_expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode_3d;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      mode_now = mode_3d;
   endtask

   // Result checking and random stalls on the result channel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flags_expected_q.size() == 0) begin
            report_mismatch("unexpected item", -1, int'(rsp_payload));
         end else begin
            oldest_flags = flags_expected_q.pop_front();
            if (oldest_flags.allow_north !== rsp_payload.allow_north)
               report_mismatch("allow_north", int'(oldest_flags.allow_north),
                               int'(rsp_payload.allow_north));
            if (oldest_flags.allow_east !== rsp_payload.allow_east)
               report_mismatch("allow_east", int'(oldest_flags.allow_east),
                               int'(rsp_payload.allow_east));
            if (oldest_flags.allow_south !== rsp_payload.allow_south)
               report_mismatch("allow_south", int'(oldest_flags.allow_south),
                               int'(rsp_payload.allow_south));
            if (oldest_flags.allow_west !== rsp_payload.allow_west)
               report_mismatch("allow_west", int'(oldest_flags.allow_west),
                               int'(rsp_payload.allow_west));
            if (oldest_flags.allow_up !== rsp_payload.allow_up)
               report_mismatch("allow_up", int'(oldest_flags.allow_up),
                               int'(rsp_payload.allow_up));
            if (oldest_flags.allow_down !== rsp_payload.allow_down)
               report_mismatch("allow_down", int'(oldest_flags.allow_down),
                               int'(rsp_payload.allow_down));
            if (oldest_flags.legal_count !== rsp_payload.legal_count)
               report_mismatch("legal_count", int'(oldest_flags.legal_count),
                               int'(rsp_payload.legal_count));
         end
      end
      rsp_stall <= take_break();
   end

   // Stimulus: directed table, then random phases that alternate the mode.
   initial begin
      route_case_type dir_cases[$];
      req_type        item;
      int             n;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_payload    <= '0;
      rsp_stall      <= 1'b0;
      csr_valid      <= 1'b0;
      csr_data       <= 1'b0;
      mode_now       = 1'b0;
      calm           = 1'b0;
      mismatch_count = 0;

      // Flag columns in typed answers: N, E, S, W, U, D, count.
      dir_cases = '{
         // 2D: at the destination only south, layers ignored; then single north and east moves.
         make_case(0, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, PREV_NORTH), 1,
                   '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1}),
         make_case(0, make_req(15, 15, 3, 15, 15, 3, 15, 15, 3, PREV_UNUSED), 1,
                   '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1}),
         make_case(0, make_req(1, 2, 1, 7, 7, 0, 7, 7, 3, PREV_NONE), 1,
                   '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1}),
         make_case(0, make_req(5, 0, 0, 5, 2, 0, 5, 9, 0, PREV_NONE), 1,
                   '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1}),
         make_case(0, make_req(0, 4, 0, 3, 4, 0, 12, 4, 0, PREV_EAST), 1,
                   '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1}),
         // 2D: westbound with no vertical offset left gives west alone; then with a vertical offset.
         make_case(0, make_req(12, 4, 0, 9, 4, 0, 1, 4, 0, PREV_WEST), 1,
                   '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 2'd1}),
         make_case(0, make_req(14, 10, 0, 8, 10, 0, 2, 3, 0, PREV_WEST), 0, '0),
         make_case(0, make_req(9, 1, 0, 7, 1, 0, 0, 15, 0, PREV_SOUTH), 0, '0),
         // 2D: eastbound into even columns with the turn blocked or allowed.
         make_case(0, make_req(0, 3, 0, 4, 3, 0, 5, 9, 0, PREV_EAST), 0, '0),
         make_case(0, make_req(0, 3, 0, 4, 3, 0, 6, 0, 0, PREV_EAST), 0, '0),
         make_case(0, make_req(4, 3, 0, 4, 3, 0, 6, 12, 0, PREV_EAST), 0, '0),
         make_case(0, make_req(0, 5, 0, 2, 5, 0, 7, 1, 0, PREV_UNUSED), 0, '0),
         make_case(0, make_req(15, 15, 3, 0, 0, 0, 15, 15, 3, PREV_EAST), 0, '0),
         // 3D: at the destination only down; then straight up and down moves.
         make_case(1, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, PREV_NORTH), 1,
                   '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1}),
         make_case(1, make_req(15, 15, 3, 15, 15, 3, 15, 15, 3, PREV_UNUSED), 1,
                   '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1}),
         make_case(1, make_req(6, 6, 0, 6, 6, 0, 6, 6, 3, PREV_UP), 1,
                   '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd1}),
         make_case(1, make_req(6, 6, 3, 6, 6, 3, 6, 6, 0, PREV_DOWN), 1,
                   '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1}),
         // 3D: southbound in the y-z plane with no layer offset left.
         make_case(1, make_req(3, 12, 2, 3, 9, 2, 3, 1, 2, PREV_SOUTH), 1,
                   '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1}),
         // 3D: westbound with nothing left in the y-z plane, then with a y-z offset, then eastbound.
         make_case(1, make_req(13, 5, 1, 10, 5, 1, 2, 5, 1, PREV_WEST), 1,
                   '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 2'd1}),
         make_case(1, make_req(9, 8, 0, 6, 8, 0, 1, 2, 3, PREV_WEST), 0, '0),
         make_case(1, make_req(14, 0, 0, 11, 0, 0, 4, 9, 2, PREV_NONE), 0, '0),
         make_case(1, make_req(0, 4, 0, 3, 4, 2, 9, 4, 2, PREV_EAST), 1,
                   '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1}),
         make_case(1, make_req(0, 0, 0, 3, 4, 0, 9, 11, 2, PREV_UP), 0, '0),
         // 3D: eastbound into an even column with the y-z turn blocked, then a move in the y-z plane.
         make_case(1, make_req(0, 0, 0, 2, 3, 1, 3, 7, 3, PREV_EAST), 0, '0),
         make_case(1, make_req(5, 0, 0, 5, 4, 3, 5, 5, 0, PREV_NORTH), 0, '0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (dir_cases[i]) begin
         if (dir_cases[i].mode_3d != mode_now) begin
            write_mode(dir_cases[i].mode_3d);
         end
         send_item(dir_cases[i].item,
                   dir_cases[i].typed ? dir_cases[i].answer
                                      : predict_route(dir_cases[i].item, mode_now));
      end

      // Random phases, with a stretch of no idling in the middle.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n % PHASE_ITEMS == 0) begin
            write_mode(((n / PHASE_ITEMS) % 2) == 1);
         end
         calm = (n >= 900 && n < 1200);
         item = random_route_req();
         send_item(item, predict_route(item, mode_now));
         n++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain and report.
      while (flags_expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule
